FILE: src/mhq_pkg.sv
// ----------------------------------------------------------------------------
// mhq_pkg
// Shared types and constants of the mesh height query block.
// ----------------------------------------------------------------------------
package mhq_pkg;

  // Default sizes, used as parameter defaults on the top level.
  localparam int DEF_MAX_VERTICES  = 1024;
  localparam int DEF_MAX_TRIANGLES = 1024;
  localparam int DEF_COORD_WIDTH   = 24;

  // Width of the vertex index fields of an appended triangle.
  localparam int IDX_W = 10;

  // Start height of the downward ray, +10000 with four fraction bits.
  localparam int RAY_TOP = 160000;

  typedef enum logic [1:0] {
    CMD_VERTEX   = 2'd0,
    CMD_TRIANGLE = 2'd1,
    CMD_QUERY    = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRI,
    ST_VA,
    ST_VB,
    ST_VC,
    ST_VL,
    ST_PROBE,
    ST_DONE
  } top_state_e;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_MUL,
    PS_ACC,
    PS_CHK,
    PS_CMP,
    PS_DIV,
    PS_FIN
  } probe_state_e;

  // Status of the triangle test unit toward the sequencer.
  typedef struct packed {
    logic done;
    logic hit;
  } probe_res_t;

  // Height reported on a miss: -10000, clipped to the coordinate range.
  function automatic int miss_height(input int cw);
    int lowest;
    lowest = -(1 << (cw - 1));
    return (-RAY_TOP < lowest) ? lowest : -RAY_TOP;
  endfunction

endpackage

FILE: src/mhq_probe.sv
// ----------------------------------------------------------------------------
// mhq_probe
// Tests one triangle against a vertical ray with a shared multiplier, an
// accumulator and a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module mhq_probe
  import mhq_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [COORD_WIDTH-1:0] vx_i [3],
  input  logic signed [COORD_WIDTH-1:0] vy_i [3],
  input  logic signed [COORD_WIDTH-1:0] vz_i [3],
  input  logic signed [COORD_WIDTH-1:0] qx_i,
  input  logic signed [COORD_WIDTH-1:0] qy_i,
  output probe_res_t                    res_o,
  output logic        [COORD_WIDTH-1:0] height_o
);

  localparam int C    = COORD_WIDTH;
  localparam int D    = C + 1;
  localparam int P    = 2 * D + 1;
  localparam int L    = D + 1;
  localparam int T    = ((C > 19) ? C : 19) + 1;
  localparam int M    = ((D + 2) > T) ? (D + 2) : T;
  localparam int W    = 2 * M + L + 1;
  localparam int CNTW = $clog2(C);

  localparam logic [3:0] StepCr    = 4'd1;
  localparam logic [3:0] StepNb    = 4'd3;
  localparam logic [3:0] StepNg    = 4'd5;
  localparam logic [3:0] StepN     = 4'd9;
  localparam logic [3:0] StepLim   = 4'd11;

  probe_state_e state_q, state_d;

  logic signed [D-1:0]   ux_q, uy_q, uz_q, wx_q, wy_q, wz_q, px_q, py_q;
  logic signed [D-1:0]   ux_d, uy_d, uz_d, wx_d, wy_d, wz_d, px_d, py_d;
  logic signed [T-1:0]   rt_q, rt_d;
  logic signed [C-1:0]   az_q, az_d;
  logic [3:0]            step_q, step_d;
  logic signed [2*M-1:0] prod_q, prod_d;
  logic signed [W-1:0]   acc_q, acc_d, n_q, n_d;
  logic signed [P-1:0]   cr_q, cr_d, nb_q, nb_d, ng_q, ng_d;
  logic [W-1:0]          rem_q, rem_d, dsh_q, dsh_d;
  logic [C-1:0]          quo_q, quo_d;
  logic                  neg_q, neg_d;
  logic [CNTW-1:0]       cnt_q, cnt_d;

  logic signed [M-1:0]   ma, mb;
  logic signed [W-1:0]   pext;
  logic signed [P-1:0]   crn, nbn, ngn;
  logic signed [P:0]     bsum;
  logic                  ge;
  logic [C-1:0]          qsgn;

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (step_q)
      4'd0: begin ma = M'(ux_q); mb = M'(wy_q); end
      4'd1: begin ma = M'(uy_q); mb = M'(wx_q); end
      4'd2: begin ma = M'(px_q); mb = M'(wy_q); end
      4'd3: begin ma = M'(py_q); mb = M'(wx_q); end
      4'd4: begin ma = M'(ux_q); mb = M'(py_q); end
      4'd5: begin ma = M'(uy_q); mb = M'(px_q); end
      4'd6: begin ma = M'($signed(nb_q[P-1:L])); mb = M'(uz_q); end
      4'd7: begin ma = M'($signed({1'b0, nb_q[L-1:0]})); mb = M'(uz_q); end
      4'd8: begin ma = M'($signed(ng_q[P-1:L])); mb = M'(wz_q); end
      4'd9: begin ma = M'($signed({1'b0, ng_q[L-1:0]})); mb = M'(wz_q); end
      4'd10: begin ma = M'($signed(cr_q[P-1:L])); mb = M'(rt_q); end
      4'd11: begin ma = M'($signed({1'b0, cr_q[L-1:0]})); mb = M'(rt_q); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    crn  = cr_q[P-1] ? -cr_q : cr_q;
    nbn  = cr_q[P-1] ? -nb_q : nb_q;
    ngn  = cr_q[P-1] ? -ng_q : ng_q;
    bsum = (P+1)'(nbn) + (P+1)'(ngn);
    pext = W'(prod_q);
    if (step_q == 4'd6 || step_q == 4'd8 || step_q == 4'd10) begin
      pext = pext <<< L;
    end
    ge   = rem_q >= dsh_q;
    qsgn = neg_q ? -quo_q : quo_q;
  end

  always_comb begin
    state_d = state_q;
    ux_d = ux_q; uy_d = uy_q; uz_d = uz_q;
    wx_d = wx_q; wy_d = wy_q; wz_d = wz_q;
    px_d = px_q; py_d = py_q;
    rt_d = rt_q; az_d = az_q;
    step_d = step_q; prod_d = prod_q; acc_d = acc_q; n_d = n_q;
    cr_d = cr_q; nb_d = nb_q; ng_d = ng_q;
    rem_d = rem_q; dsh_d = dsh_q; quo_d = quo_q; neg_d = neg_q; cnt_d = cnt_q;
    res_o = '0;
    case (state_q)
      PS_IDLE: begin
        if (start_i) begin
          ux_d = D'(vx_i[1]) - D'(vx_i[0]);
          uy_d = D'(vy_i[1]) - D'(vy_i[0]);
          uz_d = D'(vz_i[1]) - D'(vz_i[0]);
          wx_d = D'(vx_i[2]) - D'(vx_i[0]);
          wy_d = D'(vy_i[2]) - D'(vy_i[0]);
          wz_d = D'(vz_i[2]) - D'(vz_i[0]);
          px_d = D'(qx_i) - D'(vx_i[0]);
          py_d = D'(qy_i) - D'(vy_i[0]);
          rt_d = T'(RAY_TOP) - T'(vz_i[0]);
          az_d = vz_i[0];
          step_d = '0;
          state_d = PS_MUL;
        end
      end
      PS_MUL: begin
        prod_d  = ma * mb;
        state_d = PS_ACC;
      end
      PS_ACC: begin
        if (step_q == StepCr || step_q == StepNb || step_q == StepNg) begin
          acc_d = acc_q - pext;
        end else if (step_q == 4'd0 || step_q == 4'd2 || step_q == 4'd4 ||
                     step_q == 4'd6 || step_q == 4'd10) begin
          acc_d = pext;
        end else begin
          acc_d = acc_q + pext;
        end
        if (step_q == StepCr) cr_d = acc_d[P-1:0];
        if (step_q == StepNb) nb_d = acc_d[P-1:0];
        if (step_q == StepNg) ng_d = acc_d[P-1:0];
        if (step_q == StepN)  n_d  = acc_d;
        step_d = step_q + 4'd1;
        if (step_q == StepNg) begin
          state_d = PS_CHK;
        end else if (step_q == StepLim) begin
          state_d = PS_CMP;
        end else begin
          state_d = PS_MUL;
        end
      end
      PS_CHK: begin
        // Flat triangles and points outside the closed triangle miss.
        if (cr_q == '0 || nbn[P-1] || ngn[P-1] || bsum > (P+1)'(crn)) begin
          res_o.done = 1'b1;
          state_d    = PS_IDLE;
        end else begin
          cr_d    = crn;
          nb_d    = nbn;
          ng_d    = ngn;
          state_d = PS_MUL;
        end
      end
      PS_CMP: begin
        // The plane must lie at or below the ray start.
        if (n_q > acc_q) begin
          res_o.done = 1'b1;
          state_d    = PS_IDLE;
        end else begin
          neg_d   = n_q[W-1];
          rem_d   = n_q[W-1] ? W'(-n_q) : W'(n_q);
          dsh_d   = W'(cr_q) << (C - 1);
          quo_d   = '0;
          cnt_d   = CNTW'(C - 1);
          state_d = PS_DIV;
        end
      end
      PS_DIV: begin
        if (ge) rem_d = rem_q - dsh_q;
        quo_d = {quo_q[C-2:0], ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = PS_FIN;
      end
      PS_FIN: begin
        res_o.done = 1'b1;
        res_o.hit  = 1'b1;
        state_d    = PS_IDLE;
      end
      default: state_d = PS_IDLE;
    endcase
  end

  assign height_o = az_q + qsgn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ux_q <= ux_d; uy_q <= uy_d; uz_q <= uz_d;
    wx_q <= wx_d; wy_q <= wy_d; wz_q <= wz_d;
    px_q <= px_d; py_q <= py_d;
    rt_q <= rt_d; az_q <= az_d;
    step_q <= step_d; prod_q <= prod_d; acc_q <= acc_d; n_q <= n_d;
    cr_q <= cr_d; nb_q <= nb_d; ng_q <= ng_d;
    rem_q <= rem_d; dsh_q <= dsh_d; quo_q <= quo_d; neg_q <= neg_d;
    cnt_q <= cnt_d;
  end

endmodule

FILE: src/mesh_height_query.sv
// ----------------------------------------------------------------------------
// mesh_height_query
// Ground height probe over a triangle mesh held in on-chip memories.
// ----------------------------------------------------------------------------
// Usage: every input item carries a command. Append vertex and append
// triangle write the next free entry of their table; a full table, or a
// triangle that names a vertex not yet loaded, leaves the tables unchanged.
// Clear empties both tables. A height query casts a ray down from +10000
// at (x,y), walks the triangles in table order and returns one result
// item: the plane height of the first hit, or hit = 0 with -10000.
// Appends and clears give no result. A query reads, per triangle tested,
// the triangle entry and its vertices in states ST_TRI, ST_VA, ST_VB,
// ST_VC and ST_VL (one read port per memory), then runs the test unit,
// whose work is bounded by its twelve multiply-accumulate steps and the
// one-bit-per-cycle divider; early rejects finish sooner. An input item
// is taken only while no query is in progress. Results wait in an output
// register; a stalled receiver blocks only the end of the next query,
// and appends and clears go on meanwhile. Reset empties both tables by
// clearing their counts, so no memory sweep is needed.
// ----------------------------------------------------------------------------
module mesh_height_query
  import mhq_pkg::*;
#(
  parameter int MAX_VERTICES  = DEF_MAX_VERTICES,
  parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  logic signed [COORD_WIDTH-1:0] coord_z_i,
  input  logic [IDX_W-1:0]              vertex_a_i,
  input  logic [IDX_W-1:0]              vertex_b_i,
  input  logic [IDX_W-1:0]              vertex_c_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] height_o,
  output logic                          hit_o
);

  localparam int C   = COORD_WIDTH;
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int TCW = $clog2(MAX_TRIANGLES + 1);
  localparam int CW  = (VCW > IDX_W) ? VCW : IDX_W;
  localparam logic [C-1:0] MissHeight = C'(miss_height(C));

  // Vertex entries hold {z, y, x}; triangle entries hold {c, b, a}.
  logic [3*C-1:0]   vmem [MAX_VERTICES];
  logic [3*VAW-1:0] tmem [MAX_TRIANGLES];

  top_state_e        state_q, state_d;
  logic [VCW-1:0]    vcnt_q, vcnt_d;
  logic [TCW-1:0]    tcnt_q, tcnt_d;
  logic [TCW-1:0]    tidx_q, tidx_d;
  logic [3*C-1:0]    vrd_q;
  logic [3*VAW-1:0]  trd_q, tri_q, tri_d;
  logic [VAW-1:0]    vraddr;
  logic              vwe, twe;
  logic signed [C-1:0] qx_q, qx_d, qy_q, qy_d;
  logic signed [C-1:0] vx_q [3], vy_q [3], vz_q [3];
  logic              start_q, start_d;
  logic              out_valid_q, out_valid_d;
  logic [C-1:0]      height_q, height_d;
  logic              hit_q, hit_d;
  logic              found_q, found_d;
  logic [C-1:0]      fheight_q, fheight_d;
  logic              accept, out_free;
  logic              tri_ok;
  probe_res_t        pres;
  logic [C-1:0]      pheight;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign height_o    = height_q;
  assign hit_o       = hit_q;

  assign tri_ok = (tcnt_q < TCW'(MAX_TRIANGLES)) &&
                  (CW'(vertex_a_i) < CW'(vcnt_q)) &&
                  (CW'(vertex_b_i) < CW'(vcnt_q)) &&
                  (CW'(vertex_c_i) < CW'(vcnt_q));

  always_comb begin
    case (state_q)
      ST_VA:   vraddr = trd_q[VAW-1:0];
      ST_VB:   vraddr = tri_q[2*VAW-1:VAW];
      ST_VC:   vraddr = tri_q[3*VAW-1:2*VAW];
      default: vraddr = tri_q[VAW-1:0];
    endcase
  end

  always_comb begin
    state_d     = state_q;
    vcnt_d      = vcnt_q;
    tcnt_d      = tcnt_q;
    tidx_d      = tidx_q;
    tri_d       = tri_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    start_d     = 1'b0;
    vwe         = 1'b0;
    twe         = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    height_d    = height_q;
    hit_d       = hit_q;
    found_d     = found_q;
    fheight_d   = fheight_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i))
            CMD_VERTEX: begin
              if (vcnt_q < VCW'(MAX_VERTICES)) begin
                vwe    = 1'b1;
                vcnt_d = vcnt_q + 1'b1;
              end
            end
            CMD_TRIANGLE: begin
              if (tri_ok) begin
                twe    = 1'b1;
                tcnt_d = tcnt_q + 1'b1;
              end
            end
            CMD_QUERY: begin
              qx_d    = coord_x_i;
              qy_d    = coord_y_i;
              tidx_d  = '0;
              found_d = 1'b0;
              if (tcnt_q == '0) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_TRI;
              end
            end
            CMD_CLEAR: begin
              vcnt_d = '0;
              tcnt_d = '0;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_TRI: state_d = ST_VA;
      ST_VA: begin
        tri_d   = trd_q;
        state_d = ST_VB;
      end
      ST_VB: state_d = ST_VC;
      ST_VC: state_d = ST_VL;
      ST_VL: begin
        start_d = 1'b1;
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (pres.done) begin
          if (pres.hit) begin
            // The hit height is captured as the test unit reports it.
            found_d   = 1'b1;
            fheight_d = pheight;
            state_d   = ST_DONE;
          end else if (tidx_q + 1'b1 == tcnt_q) begin
            state_d = ST_DONE;
          end else begin
            tidx_d  = tidx_q + 1'b1;
            state_d = ST_TRI;
          end
        end
      end
      ST_DONE: begin
        // The output register is only loaded once the previous result left.
        if (out_free) begin
          out_valid_d = 1'b1;
          hit_d       = found_q;
          height_d    = found_q ? fheight_q : MissHeight;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      vmem[vcnt_q[VAW-1:0]] <= {coord_z_i, coord_y_i, coord_x_i};
    end
    vrd_q <= vmem[vraddr];
  end

  always_ff @(posedge clk_i) begin
    if (twe) begin
      tmem[tcnt_q[TAW-1:0]] <= {VAW'(vertex_c_i), VAW'(vertex_b_i), VAW'(vertex_a_i)};
    end
    trd_q <= tmem[tidx_q[TAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    tri_q <= tri_d;
    qx_q  <= qx_d;
    qy_q  <= qy_d;
    height_q <= height_d;
    hit_q <= hit_d;
    found_q <= found_d;
    fheight_q <= fheight_d;
    tidx_q <= tidx_d;
    if (state_q == ST_VB) begin
      vx_q[0] <= vrd_q[C-1:0];
      vy_q[0] <= vrd_q[2*C-1:C];
      vz_q[0] <= vrd_q[3*C-1:2*C];
    end
    if (state_q == ST_VC) begin
      vx_q[1] <= vrd_q[C-1:0];
      vy_q[1] <= vrd_q[2*C-1:C];
      vz_q[1] <= vrd_q[3*C-1:2*C];
    end
    if (state_q == ST_VL) begin
      vx_q[2] <= vrd_q[C-1:0];
      vy_q[2] <= vrd_q[2*C-1:C];
      vz_q[2] <= vrd_q[3*C-1:2*C];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcnt_q      <= '0;
      tcnt_q      <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcnt_q      <= vcnt_d;
      tcnt_q      <= tcnt_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  mhq_probe #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_probe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .vx_i    (vx_q),
    .vy_i    (vy_q),
    .vz_i    (vz_q),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .res_o   (pres),
    .height_o(pheight)
  );

endmodule

FILE: src/mhq_checker.sv
// ----------------------------------------------------------------------------
// mhq_checker
// Port-level checks of the mesh height query block, bound to the top level.
// ----------------------------------------------------------------------------
module mhq_checker
  import mhq_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [1:0]             cmd_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [COORD_WIDTH-1:0] height_o,
  input logic                   hit_o
);

  localparam logic [COORD_WIDTH-1:0] MissHeight = COORD_WIDTH'(miss_height(COORD_WIDTH));

  // A result held back by the receiver keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(height_o) && $stable(hit_o))
    else $error("stalled result changed");

  // A miss always reports the fixed miss height.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> height_o == MissHeight)
    else $error("miss height wrong");

  // A query occupies the block right after it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_QUERY |=> in_stall_o)
    else $error("query did not hold off input");

  // A new result only appears at the end of a query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without query");

endmodule

bind mesh_height_query mhq_checker #(.COORD_WIDTH(COORD_WIDTH)) u_mhq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .cmd_i      (cmd_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .height_o   (height_o),
  .hit_o      (hit_o)
);
